// ===== hdl/allr_pkg.sv =====
// Shared types and constants for the box line reorder block.
package allr_pkg;

    localparam logic [2:0] CMD_INIT    = 3'd0;
    localparam logic [2:0] CMD_LEFT    = 3'd1;
    localparam logic [2:0] CMD_RIGHT   = 3'd2;
    localparam logic [2:0] CMD_SWAP    = 3'd3;
    localparam logic [2:0] CMD_REVERSE = 3'd4;
    localparam logic [2:0] CMD_REPORT  = 3'd5;

    localparam int unsigned SUM_W = 24;

    // datapath controls: read address, captures, link writes, walk and report sum
    typedef struct packed {
        logic       rd_en;      // unused; the read ports always read at the address rd_sel picks
        logic [1:0] rd_sel;     // 0: x, 1: y, 2: walk pointer
        logic       cap_x;      // capture lx, rx
        logic       cap_y;      // capture ly, ry
        logic       wr_en;
        logic [2:0] wr_step;    // which join of the relink sequence
        logic       init_wr;    // write init pattern at walk index
        logic       walk_clr;
        logic       walk_step;  // advance walk index / pointer
        logic       sum_add;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_last;
        logic adjacent;     // x and y are neighbors, from the captured links
        logic ry_is_x;
        logic ly_is_x;
    } dp_stat_t;

endpackage

// ===== hdl/allr_datapath.sv =====
// Link tables, walk counter and report accumulator.
module allr_datapath #(
    parameter int unsigned AW = 13
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  allr_pkg::dp_cmd_t        cmd,
    input  logic [AW-1:0]            box_x,
    input  logic [AW-1:0]            box_y,
    input  logic [AW-1:0]            n,
    input  logic                     rev,
    input  logic [2:0]               op,
    output allr_pkg::dp_stat_t       stat,
    output logic [allr_pkg::SUM_W-1:0] sum_out
);
    logic [AW-1:0] left_mem [0:(1<<AW)-1];
    logic [AW-1:0] right_mem [0:(1<<AW)-1];
    logic [AW-1:0] l_rd, r_rd, rd_addr;
    logic [AW-1:0] lx_reg, rx_reg, ly_reg, ry_reg;
    logic [AW-1:0] walk_reg, ptr_reg;
    logic          odd_reg;
    logic [allr_pkg::SUM_W-1:0] sum_reg;
    logic [allr_pkg::SUM_W-1:0] out_reg;
    logic [AW-1:0] wa, wb;
    logic          wl, wr;
    logic [AW-1:0] il, ir;
    logic [2*AW:0] tri_n;

    always_comb begin
        case (cmd.rd_sel)
            2'd0:    rd_addr = box_x;
            2'd1:    rd_addr = box_y;
            default: rd_addr = ptr_reg;
        endcase
    end

    // join(a,b): right[a]=b, left[b]=a; op already direction-adjusted
    always_comb begin
        wa = '0; wb = '0; wl = 1'b1; wr = 1'b1;
        case (op)
            allr_pkg::CMD_LEFT: begin
                case (cmd.wr_step)
                    3'd0: begin wa = lx_reg; wb = rx_reg; end
                    3'd1: begin wa = ly_reg; wb = box_x;  end
                    default: begin wa = box_x; wb = box_y; end
                endcase
            end
            allr_pkg::CMD_RIGHT: begin
                case (cmd.wr_step)
                    3'd0: begin wa = lx_reg; wb = rx_reg; end
                    3'd1: begin wa = box_y;  wb = box_x;  end
                    default: begin wa = box_x; wb = ry_reg; end
                endcase
            end
            default: begin
                if (rx_reg == box_y) begin
                    case (cmd.wr_step)
                        3'd0: begin wa = lx_reg; wb = box_y;  end
                        3'd1: begin wa = box_x;  wb = ry_reg; end
                        default: begin wa = box_y; wb = box_x; end
                    endcase
                end else if (ry_reg == box_x) begin
                    case (cmd.wr_step)
                        3'd0: begin wa = ly_reg; wb = box_x;  end
                        3'd1: begin wa = box_y;  wb = rx_reg; end
                        default: begin wa = box_x; wb = box_y; end
                    endcase
                end else begin
                    case (cmd.wr_step)
                        3'd0: begin wa = lx_reg; wb = box_y;  end
                        3'd1: begin wa = box_y;  wb = rx_reg; end
                        3'd2: begin wa = ly_reg; wb = box_x;  end
                        default: begin wa = box_x; wb = ry_reg; end
                    endcase
                end
            end
        endcase
    end

    assign il = (walk_reg == '0) ? n : walk_reg - 1'b1;
    assign ir = (walk_reg == n) ? '0 : walk_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (cmd.init_wr) begin
            left_mem[walk_reg]  <= il;
            right_mem[walk_reg] <= ir;
        end else if (cmd.wr_en) begin
            if (wr) right_mem[wa] <= wb;
            if (wl) left_mem[wb]  <= wa;
        end
        l_rd <= left_mem[rd_addr];
        r_rd <= right_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_x) begin lx_reg <= l_rd; rx_reg <= r_rd; end
        if (cmd.cap_y) begin ly_reg <= l_rd; ry_reg <= r_rd; end
    end

    assign tri_n = ({{(AW+1){1'b0}}, n} * {{AW{1'b0}}, n + 1'b1}) >> 1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg <= '0; ptr_reg <= '0; odd_reg <= 1'b1; sum_reg <= '0;
        end else begin
            if (cmd.walk_clr) begin
                walk_reg <= '0; ptr_reg <= '0; odd_reg <= 1'b1; sum_reg <= '0;
            end else if (cmd.walk_step) begin
                walk_reg <= walk_reg + 1'b1;
                ptr_reg  <= r_rd;
                odd_reg  <= ~odd_reg;
            end
            if (cmd.sum_add && odd_reg)
                sum_reg <= sum_reg + allr_pkg::SUM_W'(r_rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load)
            out_reg <= (rev && !n[0]) ? allr_pkg::SUM_W'(tri_n) - sum_reg : sum_reg;
    end

    assign sum_out = out_reg;
    assign stat.walk_last = (walk_reg == n);
    assign stat.adjacent = (rx_reg == box_y) || (ry_reg == box_x);
    assign stat.ry_is_x = (r_rd == box_x);
    assign stat.ly_is_x = (l_rd == box_x);
endmodule

// ===== hdl/allr_ctrl.sv =====
// Command sequencer for the box line reorder block.
module allr_ctrl #(
    parameter int unsigned AW = 13
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_command,
    input  logic [AW-1:0]      s_box_x,
    input  logic [AW-1:0]      s_box_y,
    input  logic [AW-1:0]      n,
    output logic               m_valid,
    input  logic               m_ready,
    input  allr_pkg::dp_stat_t stat,
    output allr_pkg::dp_cmd_t  cmd,
    output logic [2:0]         op,
    output logic [AW-1:0]      box_x,
    output logic [AW-1:0]      box_y,
    output logic               rev
);
    localparam logic [3:0] ST_IDLE = 4'd0, ST_RDX = 4'd1, ST_RDY = 4'd2,
        ST_CAPY = 4'd3, ST_WR = 4'd4, ST_INIT = 4'd5, ST_WRD = 4'd6,
        ST_WALK = 4'd7, ST_DONE = 4'd8, ST_OUT = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    op_reg, op_next;
    logic [AW-1:0] x_reg, y_reg;
    logic          rev_reg, rev_next;
    logic [2:0]    step_reg, step_next;
    logic          mv_reg, mv_next;
    logic [2:0]    eff;
    logic          ok;

    assign s_ready = (state_reg == ST_IDLE) && !(mv_reg && !m_ready);
    assign m_valid = mv_reg;
    assign op = op_reg;
    // in idle the x read is issued straight from the incoming request
    assign box_x = (state_reg == ST_IDLE) ? s_box_x : x_reg;
    assign box_y = y_reg;
    assign rev = rev_reg;

    assign ok = s_box_x != '0 && s_box_y != '0 && s_box_x <= n && s_box_y <= n
                && s_box_x != s_box_y;
    always_comb begin
        eff = s_command;
        if (rev_reg && s_command == allr_pkg::CMD_LEFT) eff = allr_pkg::CMD_RIGHT;
        if (rev_reg && s_command == allr_pkg::CMD_RIGHT) eff = allr_pkg::CMD_LEFT;
    end

    always_comb begin
        state_next = state_reg; op_next = op_reg; rev_next = rev_reg;
        step_next = step_reg; mv_next = mv_reg && !m_ready;
        cmd = '0;
        cmd.rd_sel = 2'd2;
        case (state_reg)
            ST_IDLE: begin
                cmd.rd_sel = 2'd0;
                if (s_valid && s_ready) begin
                    op_next = eff;
                    case (s_command)
                        allr_pkg::CMD_INIT: begin
                            cmd.walk_clr = 1'b1; rev_next = 1'b0; state_next = ST_INIT;
                        end
                        allr_pkg::CMD_REVERSE: rev_next = ~rev_reg;
                        allr_pkg::CMD_REPORT: begin
                            cmd.walk_clr = 1'b1; state_next = ST_WALK;
                        end
                        allr_pkg::CMD_LEFT, allr_pkg::CMD_RIGHT, allr_pkg::CMD_SWAP:
                            if (ok) state_next = ST_RDX;
                        default: ;
                    endcase
                end
            end
            ST_RDX: begin
                cmd.rd_sel = 2'd1; cmd.cap_x = 1'b1; state_next = ST_RDY;
            end
            ST_RDY: begin
                cmd.rd_sel = 2'd1; state_next = ST_CAPY;
            end
            ST_CAPY: begin
                cmd.cap_y = 1'b1; step_next = '0;
                if ((op_reg == allr_pkg::CMD_LEFT && stat.ly_is_x) ||
                    (op_reg == allr_pkg::CMD_RIGHT && stat.ry_is_x))
                    state_next = ST_IDLE;
                else
                    state_next = ST_WR;
            end
            ST_WR: begin
                cmd.wr_en = 1'b1; cmd.wr_step = step_reg;
                step_next = step_reg + 1'b1;
                state_next = ST_WRD;
            end
            ST_WRD: begin
                // last join: three for moves and adjacent swaps, four otherwise
                if (step_reg == 3'd4 || (step_reg == 3'd3 &&
                    (op_reg != allr_pkg::CMD_SWAP || stat.adjacent)))
                    state_next = ST_IDLE;
                else
                    state_next = ST_WR;
            end
            ST_INIT: begin
                cmd.init_wr = 1'b1; cmd.walk_step = 1'b1;
                if (stat.walk_last) state_next = ST_IDLE;
            end
            ST_WALK: begin
                // read issued at pointer; result lands next cycle; n steps taken
                state_next = stat.walk_last ? ST_OUT : ST_DONE;
            end
            ST_DONE: begin
                cmd.walk_step = 1'b1; cmd.sum_add = 1'b1;
                state_next = ST_WALK;
            end
            ST_OUT: begin
                if (!mv_reg) begin
                    cmd.out_load = 1'b1; mv_next = 1'b1; state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin x_reg <= s_box_x; y_reg <= s_box_y; end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; op_reg <= '0; rev_reg <= 1'b0;
            step_reg <= '0; mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next; op_reg <= op_next; rev_reg <= rev_next;
            step_reg <= step_next; mv_reg <= mv_next;
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_out_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !mv_reg) else $error("result overwritten");
    a_no_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wr_en && cmd.init_wr)) else $error("write conflict");
endmodule

// ===== hdl/array_linked_list_reorder.sv =====
// Top level: box line held as a doubly linked list with a lazy reverse flag.
// Reverse and ignored commands are handled in idle; move and swap read the links of
// x and y, then write one join at a time through the table write port. Init writes
// one entry a cycle; report walks serially along the right link table, then waits for
// the output to be free. Reset clears control and the reverse flag; link tables are
// undefined until the first init.
module array_linked_list_reorder #(
    parameter int unsigned MAX_BOXES = 4096
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [12:0]               cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_command,
    input  logic [12:0]               s_box_x,
    input  logic [12:0]               s_box_y,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [23:0]               m_odd_position_sum
);
    localparam int unsigned AW = $clog2(MAX_BOXES + 1);

    logic [12:0]   cnt_reg;
    logic [AW-1:0] n;
    logic [AW-1:0] bx, by, cx, cy;
    logic [2:0]    op;
    logic          rev;
    allr_pkg::dp_cmd_t  cmd;
    allr_pkg::dp_stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) cnt_reg <= 13'd4096;
        else if (cfg_we) cnt_reg <= cfg_wdata;
    end

    always_comb begin
        if (cnt_reg < 13'd2) n = AW'(2);
        else if (32'(cnt_reg) > MAX_BOXES) n = AW'(MAX_BOXES);
        else n = AW'(cnt_reg);
    end

    // out-of-range boxes are rejected by the controller before truncation matters
    assign bx = (32'(s_box_x) > MAX_BOXES) ? '0 : AW'(s_box_x);
    assign by = (32'(s_box_y) > MAX_BOXES) ? '0 : AW'(s_box_y);

    allr_ctrl #(.AW(AW)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command,
        .s_box_x(bx), .s_box_y(by), .n, .m_valid, .m_ready,
        .stat, .cmd, .op, .box_x(cx), .box_y(cy), .rev
    );

    allr_datapath #(.AW(AW)) u_dp (
        .aclk, .aresetn, .cmd, .box_x(cx), .box_y(cy), .n, .rev, .op,
        .stat, .sum_out(m_odd_position_sum)
    );
endmodule
